>>> rtl/lcdfb_pkg.sv
// ----------------------------------------------------------------------------
// lcdfb_pkg: shared types and constants of the lcd framebuffer flusher
// geometry, request codes, microcode word layout and bit reversal helper
// ----------------------------------------------------------------------------
`default_nettype none

package lcdfb_pkg;

	// panel geometry
	localparam int PAGES   = 8;
	localparam int COLUMNS = 128;
	localparam int WIDTH   = 128;
	localparam int HEIGHT  = 64;

	localparam int STORE_DEPTH = PAGES * COLUMNS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int STEP_W      = $clog2(COLUMNS + 3);

	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COLUMNS + 2);
	localparam logic [STEP_W-1:0] STEP_DATA = STEP_W'(3);
	localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);

	// bus command bytes
	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] CMD_COL_LO = 8'h00;

	// request codes
	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	// microprogram addresses
	localparam int UPC_W = 3;
	localparam logic [UPC_W-1:0] UP_IDLE = 3'd0;
	localparam logic [UPC_W-1:0] UP_SET  = 3'd1;
	localparam logic [UPC_W-1:0] UP_CLR  = 3'd2;
	localparam logic [UPC_W-1:0] UP_ARM  = 3'd3;
	localparam logic [UPC_W-1:0] UP_TICK = 3'd4;

	// sequencing conditions
	localparam logic [1:0] COND_GOTO     = 2'd0;
	localparam logic [1:0] COND_DISPATCH = 2'd1;
	localparam logic [1:0] COND_LAST     = 2'd2;

	typedef struct packed {
		logic             ready;
		logic [1:0]       cond;
		logic [UPC_W-1:0] target;
		logic             mem_we;
		logic             wzero;
		logic             addr_inc;
		logic             out_load;
		logic             flush_arm;
	} uword_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic accept;
		logic mem_we;
		logic wzero;
		logic addr_inc;
		logic out_load;
		logic flush_arm;
	} ctl_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic out_free;
		logic clr_last;
	} stat_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = v[i];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lcdfb_store.sv
// ----------------------------------------------------------------------------
// lcdfb_store: frame store memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_store
	import lcdfb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [7:0]        rdata_q
);

	logic [7:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/lcdfb_seq.sv
// ----------------------------------------------------------------------------
// lcdfb_seq: microcode sequencer
// step counter, control rom and jump logic
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_seq
	import lcdfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_cmd,
	input  wire stat_t      stat,
	output logic            in_ready,
	output ctl_t            ctl
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	uword_t           uw;
	logic             accept;

	function automatic uword_t ucode(input logic [UPC_W-1:0] a);
		uword_t w;
		w = '0;
		case (a)
			UP_IDLE: begin
				w.ready = 1'b1;
				w.cond  = COND_DISPATCH;
			end
			UP_SET: begin
				w.mem_we = 1'b1;
				w.target = UP_IDLE;
			end
			UP_CLR: begin
				w.mem_we   = 1'b1;
				w.wzero    = 1'b1;
				w.addr_inc = 1'b1;
				w.cond     = COND_LAST;
				w.target   = UP_IDLE;
			end
			UP_ARM: begin
				w.flush_arm = 1'b1;
				w.target    = UP_IDLE;
			end
			UP_TICK: begin
				w.out_load = 1'b1;
				w.target   = UP_IDLE;
			end
			default: begin
				w.target = UP_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic logic [UPC_W-1:0] entry(input logic [1:0] c);
		logic [UPC_W-1:0] e;
		case (c)
			CMD_SET:   e = UP_SET;
			CMD_CLEAR: e = UP_CLR;
			CMD_FLUSH: e = UP_ARM;
			CMD_TICK:  e = UP_TICK;
			default:   e = UP_IDLE;
		endcase
		return e;
	endfunction

	assign uw       = ucode(upc_q);
	assign in_ready = uw.ready & stat.out_free;
	assign accept   = in_valid & in_ready;

	always_comb begin
		case (uw.cond)
			COND_GOTO:     upc_nxt = uw.target;
			COND_DISPATCH: upc_nxt = accept ? entry(in_cmd) : upc_q;
			COND_LAST:     upc_nxt = stat.clr_last ? uw.target : upc_q;
			default:       upc_nxt = UP_IDLE;
		endcase
	end

	// reset enters the clearing loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UP_CLR;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	assign ctl.accept    = accept;
	assign ctl.mem_we    = uw.mem_we;
	assign ctl.wzero     = uw.wzero;
	assign ctl.addr_inc  = uw.addr_inc;
	assign ctl.out_load  = uw.out_load;
	assign ctl.flush_arm = uw.flush_arm;

endmodule

`default_nettype wire

>>> rtl/lcdfb_dp.sv
// ----------------------------------------------------------------------------
// lcdfb_dp: datapath
// pixel addressing, read-modify-write, flush counters and output register
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_dp
	import lcdfb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctl_t              ctl,
	output stat_t                  stat,
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        pos_x,
	input  wire logic [7:0]        pos_y,
	input  wire logic              pixel_on,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_data,
	output logic                   mem_we,
	output logic      [ADDR_W-1:0] mem_waddr,
	output logic      [7:0]        mem_wdata,
	output logic      [ADDR_W-1:0] mem_raddr,
	input  wire logic [7:0]        mem_rdata,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        bus_byte,
	output logic                   is_data,
	output logic                   frame_done
);

	logic              invert_q;
	logic [ADDR_W-1:0] addr_q;
	logic [2:0]        bit_q;
	logic              val_q;
	logic              range_q;
	logic              active_q;
	logic [PAGE_W-1:0] page_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [7:0]        bus_q;
	logic              data_q;
	logic              done_q;

	logic [8:0]        col_w;
	logic [4:0]        ypage_w;
	logic              in_range;
	logic [ADDR_W-1:0] pix_addr;
	logic [ADDR_W-1:0] flush_addr;
	logic [7:0]        mask;
	logic [7:0]        cmd_byte;
	logic              step_is_data;
	logic              step_end;

	// mirrored column and page of the pixel
	assign col_w    = 9'(WIDTH - 1) - {1'b0, pos_x};
	assign ypage_w  = pos_y[7:3];
	assign in_range = ({1'b0, pos_x} < 9'(WIDTH)) && ({1'b0, pos_y} < 9'(HEIGHT))
		&& (col_w < 9'(COLUMNS)) && ({1'b0, ypage_w} < 6'(PAGES));
	assign pix_addr   = ADDR_W'(int'(ypage_w) * COLUMNS + int'(col_w));
	assign flush_addr = ADDR_W'(int'(page_q) * COLUMNS + int'(step_q) - 3);

	// read issued on the accept edge
	assign mem_raddr = (cmd == CMD_SET) ? pix_addr : flush_addr;

	assign mask      = 8'h80 >> bit_q;
	assign mem_we    = ctl.mem_we & (ctl.wzero | range_q);
	assign mem_waddr = addr_q;
	assign mem_wdata = ctl.wzero ? 8'h00 : (val_q ? (mem_rdata | mask) : (mem_rdata & ~mask));

	assign stat.clr_last = (addr_q == ADDR_LAST);
	assign stat.out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		case (step_q)
			STEP_W'(0): cmd_byte = CMD_PAGE + 8'(page_q);
			STEP_W'(1): cmd_byte = CMD_COL_HI;
			default:    cmd_byte = CMD_COL_LO;
		endcase
	end

	assign step_is_data = (step_q >= STEP_DATA);
	assign step_end     = (step_q == STEP_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q    <= 1'b0;
			addr_q      <= '0;
			range_q     <= 1'b0;
			active_q    <= 1'b0;
			page_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				invert_q <= cfg_data;
			end
			if (ctl.accept) begin
				addr_q  <= (cmd == CMD_SET) ? pix_addr : '0;
				range_q <= (cmd == CMD_SET) & in_range;
			end else if (ctl.addr_inc) begin
				addr_q <= addr_q + ADDR_W'(1);
			end
			if (ctl.flush_arm) begin
				active_q <= 1'b1;
				page_q   <= '0;
				step_q   <= '0;
			end else if (ctl.out_load && active_q) begin
				if (step_end) begin
					step_q <= '0;
					if (page_q == PAGE_LAST) begin
						page_q   <= '0;
						active_q <= 1'b0;
					end else begin
						page_q <= page_q + PAGE_W'(1);
					end
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (ctl.out_load && active_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			bit_q <= pos_y[2:0];
			val_q <= pixel_on ^ invert_q;
		end
		if (ctl.out_load && active_q) begin
			bus_q  <= step_is_data ? mem_rdata : rev8(cmd_byte);
			data_q <= step_is_data;
			done_q <= step_end && (page_q == PAGE_LAST);
		end
	end

	assign out_valid  = out_valid_q;
	assign bus_byte   = bus_q;
	assign is_data    = data_q;
	assign frame_done = done_q;

endmodule

`default_nettype wire

>>> rtl/paged_lcd_framebuffer_flusher.sv
// ----------------------------------------------------------------------------
// paged_lcd_framebuffer_flusher: page-organized monochrome frame store with bus flusher
// set pixel, clear, start flush and tick requests driven by a microcoded sequencer
// ----------------------------------------------------------------------------
// set pixel and start flush each take the accept, then one microcode step
// tick takes the accept, then one microcode step that loads its bus byte, if any
// clear takes the accept, then a loop that writes one store byte per cycle over all bytes
// the single-port-write store sets this order: read on accept, write next step
// reset is asynchronous, active low; afterwards a clearing pass over all PAGES*COLUMNS
// store bytes runs with in_stall high, configuration writes still taken
`default_nettype none

module paged_lcd_framebuffer_flusher
	import lcdfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] pos_x,
	input  wire logic [7:0] pos_y,
	input  wire logic       pixel_on,
	// bus byte channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [7:0] bus_byte,
	output logic            is_data,
	output logic            frame_done,
	// invert register write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data
);

	ctl_t              ctl;
	stat_t             stat;
	logic              in_ready;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_rdata;

	// the register write is always taken
	assign cfg_ready = 1'b1;

	// requests only enter at the idle step of the microprogram with the output free
	assign in_stall = ~in_ready;

	// microprogram: idle/dispatch, set write-back, clear loop, flush arm, tick
	lcdfb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.stat     (stat),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	// addressing, flush counters, invert register and the output register
	lcdfb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cmd        (cmd),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pixel_on   (pixel_on),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bus_byte   (bus_byte),
		.is_data    (is_data),
		.frame_done (frame_done)
	);

	// PAGES*COLUMNS byte store, page-major, 8 vertical pixels per byte, top pixel in bit 7
	lcdfb_store u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

endmodule

`default_nettype wire

>>> rtl/lcdfb_checker.sv
// ----------------------------------------------------------------------------
// lcdfb_checker: port-level assertions for the lcd framebuffer flusher
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_checker
	import lcdfb_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] cmd,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] bus_byte,
	input wire logic       is_data,
	input wire logic       frame_done
);

	// a stalled bus byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bus_byte))
		else $error("bus byte dropped or changed under stall");

	// each taken request moves the sequencer out of its idle step, so requests are never taken back to back
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken on back-to-back cycles");

	// a new bus byte only follows a tick request, through the tick step and the output register
	a_tick_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && cmd == CMD_TICK, 2))
		else $error("bus byte without a tick request");

	// end of frame is always a data byte
	a_done_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> is_data)
		else $error("frame done on a command byte");

	// command bytes are the reversed page or column commands
	a_cmd_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |->
			(bus_byte[3:0] == 4'hD) || (bus_byte == 8'h08) || (bus_byte == 8'h00))
		else $error("malformed command byte");

endmodule

bind paged_lcd_framebuffer_flusher lcdfb_checker u_lcdfb_checker (.*);

`default_nettype wire

>>> test/lcd_bus_checker.sv
// ----------------------------------------------------------------------------
// lcd_bus_checker: shadow frame store and bus byte scoreboard
// watches the request, bus byte and invert register channels of the lcd
// flusher, keeps its own copy of the store and flush position, and compares
// every bus byte with the oldest byte predicted for it
// ----------------------------------------------------------------------------

module lcd_bus_checker
	import lcdfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] pos_x,
	input  wire logic [7:0] pos_y,
	input  wire logic       pixel_on,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] bus_byte,
	input  wire logic       is_data,
	input  wire logic       frame_done,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic       cfg_data,
	output int              errors,
	output int              due
);

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       is_data;
		logic       frame_done;
	} bus_beat_t;

	bus_beat_t   bytes_due[$];
	logic [7:0]  panel_store [STORE_DEPTH];
	logic        invert_r;
	logic        flushing;
	int unsigned page_r;
	int unsigned step_r;
	int          mismatches = 0;

	function automatic logic [7:0] flip8(input logic [7:0] v);
		flip8 = {<<{v}};
	endfunction

	// apply one accepted request to the shadow state, queue its bus byte if any
	task automatic update_panel(input logic [1:0] c, input logic [7:0] x,
			input logic [7:0] y, input logic p);
		int unsigned pg;
		int unsigned col;
		bus_beat_t   beat;
		case (c)
			CMD_SET: begin
				if (x < WIDTH && y < HEIGHT) begin
					pg  = y / 8;
					col = WIDTH - 1 - x;
					if (pg < PAGES && col < COLUMNS)
						panel_store[pg * COLUMNS + col][7 - (y % 8)] = p ^ invert_r;
				end
			end
			CMD_CLEAR: begin
				foreach (panel_store[i]) begin
					panel_store[i] = 8'h00;
				end
			end
			CMD_FLUSH: begin
				flushing = 1'b1;
				page_r   = 0;
				step_r   = 0;
			end
			CMD_TICK: begin
				if (!flushing || page_r >= PAGES) begin
					flushing = 1'b0;
				end else begin
					beat.is_data    = 1'b0;
					beat.frame_done = 1'b0;
					if (step_r == 0) begin
						beat.bus_byte = flip8(CMD_PAGE + 8'(page_r));
					end else if (step_r == 1) begin
						beat.bus_byte = flip8(CMD_COL_HI);
					end else if (step_r == 2) begin
						beat.bus_byte = flip8(CMD_COL_LO);
					end else begin
						col = step_r - 3;
						if (col >= COLUMNS)
							col = COLUMNS - 1;
						beat.bus_byte = panel_store[page_r * COLUMNS + col];
						beat.is_data  = 1'b1;
					end
					if (step_r >= COLUMNS + 2) begin
						step_r = 0;
						page_r++;
						if (page_r >= PAGES) begin
							page_r          = 0;
							flushing        = 1'b0;
							beat.frame_done = 1'b1;
						end
					end else begin
						step_r++;
					end
					bytes_due.push_back(beat);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_byte();
		bus_beat_t want;
		if (bytes_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("checker: unexpected bus byte %h is_data %b frame_done %b",
					bus_byte, is_data, frame_done);
		end else begin
			want = bytes_due.pop_front();
			if (want.bus_byte !== bus_byte || want.is_data !== is_data ||
					want.frame_done !== frame_done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("checker: bus byte mismatch, expected %h/%b/%b got %h/%b/%b",
						want.bus_byte, want.is_data, want.frame_done,
						bus_byte, is_data, frame_done);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (panel_store[i]) begin
				panel_store[i] = 8'h00;
			end
			invert_r = 1'b0;
			flushing = 1'b0;
			page_r   = 0;
			step_r   = 0;
			bytes_due.delete();
			due <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_byte();
			if (cfg_valid && cfg_ready)
				invert_r = cfg_data;
			if (in_valid && !in_stall)
				update_panel(cmd, pos_x, pos_y, pixel_on);
			due    <= bytes_due.size();
			errors <= mismatches;
		end
	end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: lcd framebuffer flusher top level
// drives pixel, clear, flush and tick requests with random gaps, stalls the
// bus byte side at random and once for a long stretch, switches the invert
// register between phases, and takes the verdict from the bus checker
// ----------------------------------------------------------------------------

module testbench;
	import lcdfb_pkg::*;

	// clock, reset and block inputs, all known from time zero
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [1:0] cmd       = CMD_TICK;
	logic [7:0] pos_x     = 8'h00;
	logic [7:0] pos_y     = 8'h00;
	logic       pixel_on  = 1'b0;
	logic       out_stall = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_data  = 1'b0;

	// block outputs
	logic       in_stall;
	logic       out_valid;
	logic [7:0] bus_byte;
	logic       is_data;
	logic       frame_done;
	logic       cfg_ready;

	// checker results
	int         fail_count;
	int         due_count;

	// idling control shared by sender and receiver
	logic       calm      = 1'b0;	// no random gaps or stalls while set
	logic       hold_kick = 1'b0;	// asks the receiver for one long hold-off
	bit         hold_taken = 1'b0;
	int         hold_left  = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	paged_lcd_framebuffer_flusher u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pixel_on   (pixel_on),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bus_byte   (bus_byte),
		.is_data    (is_data),
		.frame_done (frame_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	lcd_bus_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pixel_on   (pixel_on),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bus_byte   (bus_byte),
		.is_data    (is_data),
		.frame_done (frame_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.errors     (fail_count),
		.due        (due_count)
	);

	// bus side: random stalls, plus one long hold-off counted here so that
	// the flusher backs up and stalls its request input
	initial begin
		forever begin
			@(posedge clk);
			if (hold_kick && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 300;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 15);
			end
		end
	end

	// offer one request; valid stays high across back-to-back requests
	task automatic offer_request(input logic [1:0] c, input logic [7:0] x,
			input logic [7:0] y, input logic p);
		while (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		pos_x    <= x;
		pos_y    <= y;
		pixel_on <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// mostly on-panel coordinates, one in five over the full 8-bit range
	task automatic offer_pixel();
		logic [7:0] x;
		logic [7:0] y;
		x = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, WIDTH - 1));
		y = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, HEIGHT - 1));
		offer_request(CMD_SET, x, y, 1'($urandom_range(0, 1)));
	endtask

	// request with junk coordinates, which the block must ignore
	task automatic offer_plain(input logic [1:0] c);
		offer_request(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	// random mix: pixels and ticks, some flush restarts, rare clears
	task automatic offer_mix(input int count);
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				offer_plain(CMD_CLEAR);
			else if (pick < 8)
				offer_plain(CMD_FLUSH);
			else if (pick < 52)
				offer_pixel();
			else
				offer_plain(CMD_TICK);
		end
	endtask

	// one whole frame: flush, then enough ticks for every page with pixel
	// writes mixed in, then a few ticks past the end while idle
	task automatic offer_frame();
		int ticks;
		ticks = 0;
		offer_plain(CMD_FLUSH);
		while (ticks < PAGES * (COLUMNS + 3) + 6) begin
			if ($urandom_range(0, 99) < 15) begin
				offer_pixel();
			end else begin
				offer_plain(CMD_TICK);
				ticks++;
			end
			// long bus hold-off early, then a stretch with no idling at all
			if (ticks == 40)
				hold_kick <= 1'b1;
			if (ticks == 300)
				calm <= 1'b1;
			if (ticks == 750)
				calm <= 1'b0;
		end
	endtask

	// drop valid, wait for every bus byte, then cover a clear still running
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	task automatic write_invert(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_invert(1'b0);

		// directed: tick while idle, corner pixels, dropped pixels
		offer_request(CMD_TICK,  8'd0,   8'd0,   1'b0);
		offer_request(CMD_SET,   8'd0,   8'd0,   1'b1);
		offer_request(CMD_SET,   8'd127, 8'd63,  1'b1);
		offer_request(CMD_SET,   8'd128, 8'd0,   1'b1);
		offer_request(CMD_SET,   8'd0,   8'd64,  1'b1);
		offer_request(CMD_SET,   8'd255, 8'd255, 1'b1);
		offer_request(CMD_SET,   8'd5,   8'd9,   1'b1);
		offer_request(CMD_SET,   8'd5,   8'd9,   1'b0);
		offer_request(CMD_SET,   8'd64,  8'd32,  1'b1);
		// flush: three command bytes, then data
		offer_request(CMD_FLUSH, 8'd0,   8'd0,   1'b0);
		repeat (4) offer_request(CMD_TICK, 8'hff, 8'hff, 1'b1);
		// pixel written mid-flush shows up in the next data byte
		offer_request(CMD_SET,   8'd126, 8'd0,   1'b1);
		offer_request(CMD_TICK,  8'd0,   8'd0,   1'b0);
		// restart while flushing goes back to page 0 commands
		offer_request(CMD_FLUSH, 8'd0,   8'd0,   1'b0);
		repeat (3) offer_request(CMD_TICK, 8'd0, 8'd0, 1'b0);
		// clear mid-flush, data bytes then read zero
		offer_request(CMD_CLEAR, 8'd0,   8'd0,   1'b0);
		repeat (2) offer_request(CMD_TICK, 8'd0, 8'd0, 1'b0);
		settle();

		write_invert(1'b1);
		offer_mix(300);
		settle();

		write_invert(1'b0);
		offer_frame();
		settle();

		write_invert(1'b1);
		offer_mix(300);
		settle();

		if (fail_count == 0 && due_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#3200000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
